// File: sv/tww_pkg.sv
package tww_pkg;

    // Field widths
    localparam int CODE_W  = 21;
    localparam int ADV_W   = 12;
    localparam int X_W     = 16;
    localparam int Y_W     = 24;
    localparam int H_W     = 8;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    // Default word buffer depth
    localparam int WORD_CAPACITY_DEF = 32;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_WRAP_WIDTH = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_LINE_H0    = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_LINE_H1    = 2'd2;

    // Configuration reset values
    localparam logic [X_W-1:0] WRAP_WIDTH_RST = 16'd8192;
    localparam logic [H_W-1:0] LINE_H0_RST    = 8'd46;
    localparam logic [H_W-1:0] LINE_H1_RST    = 8'd38;

    // Character codes
    localparam logic [CODE_W-1:0] CH_ESCAPE  = 21'd64;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 21'd10;
    localparam logic [CODE_W-1:0] CH_SPACE   = 21'd32;
    localparam logic [CODE_W-1:0] CH_ZERO    = 21'd48;
    localparam logic [CODE_W-1:0] CH_ONE     = 21'd49;

    // Lowest line y
    localparam logic [Y_W-1:0] Y_MIN = 24'h800000;

    // One buffered word character
    typedef struct packed {
        logic [ADV_W-1:0]  adv;
        logic [CODE_W-1:0] code;
    } t_word_entry;

    // Word placement captured when a flush starts
    typedef struct packed {
        logic [X_W-1:0]        origin_x;
        logic signed [Y_W-1:0] line_y;
        logic                  font;
        logic                  overflowed;
    } t_flush_info;

    // Emitter states
    typedef enum logic {
        EM_IDLE,
        EM_READ
    } t_em_state;

    // Unsigned add, saturating at the top of 16 bits
    function automatic logic [X_W-1:0] sat_add16(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
        logic [X_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[X_W] ? {X_W{1'b1}} : s[X_W-1:0];
    endfunction

endpackage

// File: sv/tww_word_mem.sv
module tww_word_mem #(
    parameter int DEPTH = tww_pkg::WORD_CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  tww_pkg::t_word_entry i_wr_data,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output tww_pkg::t_word_entry o_rd_data
);

    tww_pkg::t_word_entry mem [DEPTH];
    tww_pkg::t_word_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/tww_emitter.sv
module tww_emitter #(
    parameter int WORD_CAPACITY = tww_pkg::WORD_CAPACITY_DEF,
    parameter int AW            = $clog2(WORD_CAPACITY)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // flush request from the character path
    input  logic                 i_start,
    input  logic [AW-1:0]        i_last_idx,
    input  tww_pkg::t_flush_info i_info,
    output logic                 o_busy,
    // word memory read port
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  tww_pkg::t_word_entry i_rd_data,
    // result stream
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [tww_pkg::CODE_W-1:0] o_code,
    output logic                 o_font,
    output logic [tww_pkg::X_W-1:0] o_pen_x,
    output logic [tww_pkg::Y_W-1:0] o_pen_y,
    output logic                 o_last,
    output logic                 o_trunc
);

    tww_pkg::t_em_state r_state, n_state;
    tww_pkg::t_flush_info r_info;
    logic [AW-1:0]          r_rd_addr;
    logic [AW-1:0]          r_last_idx;
    logic                   r_rd_valid;
    logic                   r_rd_last;
    logic [tww_pkg::X_W-1:0] r_x;

    logic                   r_out_valid;
    logic [tww_pkg::CODE_W-1:0] r_out_code;
    logic                   r_out_font;
    logic [tww_pkg::X_W-1:0] r_out_x;
    logic [tww_pkg::Y_W-1:0] r_out_y;
    logic                   r_out_last;
    logic                   r_out_trunc;

    logic out_free;
    logic s1_move;
    logic rd_en;
    logic out_load;

    assign out_free = !r_out_valid || i_ready;
    assign s1_move  = !r_rd_valid || out_free;
    assign out_load = r_rd_valid && out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tww_pkg::EM_IDLE: begin
                if (i_start) begin
                    n_state = tww_pkg::EM_READ;
                end
            end
            tww_pkg::EM_READ: begin
                if (rd_en && (r_rd_addr == r_last_idx)) begin
                    n_state = tww_pkg::EM_IDLE;
                end
            end
            default: n_state = tww_pkg::EM_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        rd_en = 1'b0;
        unique case (r_state)
            tww_pkg::EM_IDLE: rd_en = 1'b0;
            tww_pkg::EM_READ: rd_en = s1_move;
            default:          rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tww_pkg::EM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Read address and captured placement
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd_addr  <= '0;
            r_last_idx <= i_last_idx;
            r_info     <= i_info;
        end else if (rd_en) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
    end

    // Read stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (rd_en) begin
            r_rd_valid <= 1'b1;
        end else if (out_free) begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_last <= (r_rd_addr == r_last_idx);
        end
    end

    // Pen x runs along the word
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_info.origin_x;
        end else if (out_load) begin
            r_x <= tww_pkg::sat_add16(r_x, {{(tww_pkg::X_W-tww_pkg::ADV_W){1'b0}},
                                            i_rd_data.adv});
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_code  <= i_rd_data.code;
            r_out_font  <= r_info.font;
            r_out_x     <= r_x;
            r_out_y     <= r_info.line_y;
            r_out_last  <= r_rd_last;
            r_out_trunc <= r_info.overflowed;
        end
    end

    assign o_busy    = (r_state != tww_pkg::EM_IDLE) || r_rd_valid;
    assign o_rd_en   = rd_en;
    assign o_rd_addr = r_rd_addr;
    assign o_valid   = r_out_valid;
    assign o_code    = r_out_code;
    assign o_font    = r_out_font;
    assign o_pen_x   = r_out_x;
    assign o_pen_y   = r_out_y;
    assign o_last    = r_out_last;
    assign o_trunc   = r_out_trunc;

    // A new flush only starts once the previous word is fully read
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == tww_pkg::EM_IDLE) && !r_rd_valid)
        else $error("flush started while emitter busy");

    // A glyph waiting at the output holds until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid && $stable(r_out_code)
            && $stable(r_out_x) && $stable(r_out_last))
        else $error("glyph changed under back-pressure");

    // Read stage holds its data while the output is stalled
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !out_free) |=> r_rd_valid && $stable(r_rd_last))
        else $error("read stage lost under back-pressure");

endmodule

// File: sv/text_word_wrap_layout.sv
// Greedy word-wrap layout, one character per request.
// A character that closes no word starts no flush and ready stays high.
// A character that closes a word of L glyphs holds ready low while the word is read out:
// the word memory is read one entry a cycle unless the output stalls; each glyph passes
// the read register and the output register, one glyph a cycle unless the output stalls.
// Synchronous active-low reset clears control state, loads default configuration.
module text_word_wrap_layout #(
    parameter int WORD_CAPACITY = tww_pkg::WORD_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [tww_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [tww_pkg::CFG_D_W-1:0] i_cfg_data,
    // character requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // char_code[20:0], glyph_advance[32:21], zero pad
    input  logic        s_axis_tlast,   // end_of_text
    // placed glyphs
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // glyph_code[20:0], pen_x[36:21], pen_y[60:37], pad
    output logic [1:0]  m_axis_tuser,   // font_index[0], word_truncated[1]
    output logic        m_axis_tlast    // last_in_run
);

    localparam int AW = $clog2(WORD_CAPACITY);
    localparam int LW = $clog2(WORD_CAPACITY + 1);
    localparam logic [LW-1:0] CAP = LW'(WORD_CAPACITY);

    localparam int X_W = tww_pkg::X_W;
    localparam int Y_W = tww_pkg::Y_W;
    localparam int H_W = tww_pkg::H_W;

    // Configuration
    logic [X_W-1:0] r_wrap_width;
    logic [H_W-1:0] r_line_h0;
    logic [H_W-1:0] r_line_h1;

    // Layout state
    logic [X_W-1:0] r_cursor_x,   n_cursor_x;
    logic [Y_W-1:0] r_line_y,     n_line_y;
    logic [H_W-1:0] r_cur_h,      n_cur_h;
    logic           r_font,       n_font;
    logic           r_esc,        n_esc;
    logic           r_word_open,  n_word_open;
    logic [X_W-1:0] r_origin_x,   n_origin_x;
    logic [X_W-1:0] r_word_width, n_word_width;
    logic [LW-1:0]  r_word_len,   n_word_len;
    logic           r_word_ovf,   n_word_ovf;

    // Request fields
    logic                       accept;
    logic [tww_pkg::CODE_W-1:0] in_code;
    logic [tww_pkg::ADV_W-1:0]  in_adv;
    logic                       in_eot;
    logic [X_W-1:0]             adv_x;

    // Word memory write and flush request
    logic                 wr_en;
    tww_pkg::t_word_entry wr_data;
    logic                 pre_flush;
    logic                 post_flush;
    logic                 flush_start;
    logic [AW-1:0]        flush_last;
    tww_pkg::t_flush_info flush_info;

    // Emitter links
    logic                 em_busy;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    tww_pkg::t_word_entry rd_data;

    logic [tww_pkg::CODE_W-1:0] out_code;
    logic                       out_font;
    logic [X_W-1:0]             out_x;
    logic [Y_W-1:0]             out_y;
    logic                       out_trunc;

    // Line step down with floor at the lowest y
    logic [Y_W:0]   down_diff;
    logic [Y_W-1:0] line_down;

    // Scratch for word characters
    logic [X_W-1:0] w_width0;
    logic [LW-1:0]  w_len0;
    logic [X_W-1:0] cur_sum;
    logic [H_W-1:0] esc_h;
    logic [H_W-1:0] font_h;

    assign in_code = s_axis_tdata[20:0];
    assign in_adv  = s_axis_tdata[32:21];
    assign in_eot  = s_axis_tlast;
    assign adv_x   = {{(X_W-tww_pkg::ADV_W){1'b0}}, in_adv};

    assign s_axis_tready = !em_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign down_diff = {r_line_y[Y_W-1], r_line_y} - {{(Y_W+1-H_W){1'b0}}, r_cur_h};
    assign line_down = (down_diff[Y_W] != down_diff[Y_W-1]) ? tww_pkg::Y_MIN
                                                            : down_diff[Y_W-1:0];
    assign font_h    = r_font ? r_line_h1 : r_line_h0;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= tww_pkg::WRAP_WIDTH_RST;
            r_line_h0    <= tww_pkg::LINE_H0_RST;
            r_line_h1    <= tww_pkg::LINE_H1_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tww_pkg::CFG_WRAP_WIDTH: r_wrap_width <= i_cfg_data;
                tww_pkg::CFG_LINE_H0:    r_line_h0    <= i_cfg_data[H_W-1:0];
                tww_pkg::CFG_LINE_H1:    r_line_h1    <= i_cfg_data[H_W-1:0];
                default: ;
            endcase
        end
    end

    // Character step: layout update, word store write and flush decision
    always_comb begin
        n_cursor_x   = r_cursor_x;
        n_line_y     = r_line_y;
        n_cur_h      = r_cur_h;
        n_font       = r_font;
        n_esc        = r_esc;
        n_word_open  = r_word_open;
        n_origin_x   = r_origin_x;
        n_word_width = r_word_width;
        n_word_len   = r_word_len;
        n_word_ovf   = r_word_ovf;
        wr_en        = 1'b0;
        wr_data      = '{adv: in_adv, code: in_code};
        pre_flush    = 1'b0;
        post_flush   = 1'b0;
        w_width0     = r_word_width;
        w_len0       = r_word_len;
        cur_sum      = '0;
        esc_h        = in_code[0] ? r_line_h1 : r_line_h0;

        if (r_esc) begin
            // font digit after the escape
            n_esc = 1'b0;
            if ((in_code == tww_pkg::CH_ZERO) || (in_code == tww_pkg::CH_ONE)) begin
                n_font = in_code[0];
                if ((r_cursor_x == '0) || (esc_h > r_cur_h)) begin
                    n_cur_h = esc_h;
                end
            end
        end else if (in_code == tww_pkg::CH_ESCAPE) begin
            pre_flush   = r_word_open;
            n_word_open = 1'b0;
            n_esc       = 1'b1;
        end else if (in_code == tww_pkg::CH_NEWLINE) begin
            pre_flush   = r_word_open;
            n_word_open = 1'b0;
            n_line_y    = line_down;
            n_cursor_x  = '0;
            n_cur_h     = font_h;
        end else begin
            if (in_code == tww_pkg::CH_SPACE) begin
                pre_flush   = r_word_open;
                n_word_open = 1'b0;
            end else begin
                // word character: open a word if none, then buffer it
                if (!r_word_open) begin
                    n_word_open = 1'b1;
                    n_origin_x  = r_cursor_x;
                    w_width0    = '0;
                    w_len0      = '0;
                    n_word_ovf  = 1'b0;
                end
                if (w_len0 < CAP) begin
                    wr_en      = 1'b1;
                    n_word_len = w_len0 + LW'(1);
                end else begin
                    n_word_len = w_len0;
                    n_word_ovf = 1'b1;
                end
                n_word_width = tww_pkg::sat_add16(w_width0, adv_x);
            end
            cur_sum    = tww_pkg::sat_add16(r_cursor_x, adv_x);
            n_cursor_x = cur_sum;
            // past the limit: a new line starts and the open word, if any, moves to it
            if (cur_sum > r_wrap_width) begin
                n_origin_x = '0;
                n_cursor_x = n_word_open ? n_word_width : '0;
                n_line_y   = line_down;
                n_cur_h    = font_h;
            end
        end

        if (in_eot) begin
            post_flush  = n_word_open;
            n_word_open = 1'b0;
            n_esc       = 1'b0;
        end
    end

    // Flush placement: before the update for closing characters, after it at end of text
    always_comb begin
        if (pre_flush) begin
            flush_info = '{origin_x: r_origin_x, line_y: r_line_y,
                           font: r_font, overflowed: r_word_ovf};
            flush_last = AW'(r_word_len - LW'(1));
        end else begin
            flush_info = '{origin_x: n_origin_x, line_y: n_line_y,
                           font: n_font, overflowed: n_word_ovf};
            flush_last = AW'(n_word_len - LW'(1));
        end
    end

    assign flush_start = accept && (pre_flush || post_flush);

    // Layout state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x   <= '0;
            r_line_y     <= '0;
            r_cur_h      <= tww_pkg::LINE_H0_RST;
            r_font       <= 1'b0;
            r_esc        <= 1'b0;
            r_word_open  <= 1'b0;
            r_origin_x   <= '0;
            r_word_width <= '0;
            r_word_len   <= '0;
            r_word_ovf   <= 1'b0;
        end else if (accept) begin
            r_cursor_x   <= n_cursor_x;
            r_line_y     <= n_line_y;
            r_cur_h      <= n_cur_h;
            r_font       <= n_font;
            r_esc        <= n_esc;
            r_word_open  <= n_word_open;
            r_origin_x   <= n_origin_x;
            r_word_width <= n_word_width;
            r_word_len   <= n_word_len;
            r_word_ovf   <= n_word_ovf;
        end
    end

    tww_word_mem #(
        .DEPTH (WORD_CAPACITY),
        .AW    (AW)
    ) u_word_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_en),
        .i_wr_addr (w_len0[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tww_emitter #(
        .WORD_CAPACITY (WORD_CAPACITY),
        .AW            (AW)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (flush_start),
        .i_last_idx (flush_last),
        .i_info     (flush_info),
        .o_busy     (em_busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_code     (out_code),
        .o_font     (out_font),
        .o_pen_x    (out_x),
        .o_pen_y    (out_y),
        .o_last     (m_axis_tlast),
        .o_trunc    (out_trunc)
    );

    assign m_axis_tdata = {3'b000, out_y, out_x, out_code};
    assign m_axis_tuser = {out_trunc, out_font};

    // Buffered word never grows past the memory depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_len <= CAP)
        else $error("word length beyond capacity");

    // End of text leaves no open word and no pending escape
    a_eot_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_eot) |=> !r_word_open && !r_esc)
        else $error("state left open after end of text");

    // An open word always has at least one stored character to flush
    a_open_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_open |-> (r_word_len != '0))
        else $error("open word with empty buffer");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int CODE_W      = tww_pkg::CODE_W;
    localparam int ADV_W       = tww_pkg::ADV_W;
    localparam int X_W         = tww_pkg::X_W;
    localparam int Y_W         = tww_pkg::Y_W;
    localparam int H_W         = tww_pkg::H_W;
    localparam int CFG_A_W     = tww_pkg::CFG_A_W;
    localparam int CFG_D_W     = tww_pkg::CFG_D_W;
    localparam int WORD_CAP    = tww_pkg::WORD_CAPACITY_DEF;
    localparam int Y_FLOOR     = -8388608;
    localparam int CYCLE_LIMIT = 600000;

    // one character request and the pause that follows its acceptance
    typedef struct {
        logic [CODE_W-1:0] code;
        logic [ADV_W-1:0]  adv;
        logic              eot;
        int                gap;
    } t_char_req;

    // one placed glyph
    typedef struct {
        logic [CODE_W-1:0] code;
        logic              font;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              last;
        logic              trunc;
    } t_glyph;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_index = '0;
    logic [CFG_D_W-1:0]  i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    text_word_wrap_layout DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_char_req char_req_q[$];
    t_glyph    glyph_expect_q[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        queued_count = 0;
    int        send_gap = 0;
    int        recv_stall = 0;
    bit        char_taken = 1'b0;
    bit        glyph_taken = 1'b0;
    bit        calm = 1'b0;

    // layout state mirrored from the block
    logic [X_W-1:0]        cfg_wrap;
    logic [H_W-1:0]        cfg_lh0;
    logic [H_W-1:0]        cfg_lh1;
    logic [X_W-1:0]        pen;
    logic signed [Y_W-1:0] base_y;
    logic [H_W-1:0]        line_h;
    logic                  font_sel;
    bit                    esc_wait;
    bit                    word_live;
    logic [X_W-1:0]        word_x0;
    logic [X_W-1:0]        word_w;
    logic [CODE_W-1:0]     word_code[WORD_CAP];
    logic [ADV_W-1:0]      word_adv[WORD_CAP];
    int                    word_len;
    bit                    word_cut;

    function automatic logic [X_W-1:0] add_clamp(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
        int unsigned s;
        s = int'(a) + int'(b);
        return (s > 32'hFFFF) ? 16'hFFFF : X_W'(s);
    endfunction

    function automatic logic [H_W-1:0] font_height_of(input logic f);
        return f ? cfg_lh1 : cfg_lh0;
    endfunction

    // move down one line, clamping at the bottom of the y range
    task automatic drop_line();
        int ny;
        ny = int'(base_y) - int'(line_h);
        base_y = Y_W'((ny < Y_FLOOR) ? Y_FLOOR : ny);
        line_h = font_height_of(font_sel);
    endtask

    // queue the glyphs of the open word, if any
    task automatic emit_word(inout int n);
        logic [X_W-1:0] gx;
        t_glyph         g;
        if (!word_live)
            return;
        gx = word_x0;
        for (int i = 0; i < word_len; i++) begin
            g.code  = word_code[i];
            g.font  = font_sel;
            g.x     = gx;
            g.y     = base_y;
            g.last  = 1'b0;
            g.trunc = word_cut;
            glyph_expect_q.push_back(g);
            gx = add_clamp(gx, word_adv[i]);
            n++;
        end
        word_live = 1'b0;
    endtask

    // expected glyphs for one accepted character
    task automatic place_char(input logic [CODE_W-1:0] c, input logic [ADV_W-1:0] adv,
                              input logic eot);
        int             n;
        logic [H_W-1:0] h;
        t_glyph         g;
        n = 0;
        if (esc_wait) begin
            // the character after an escape is always consumed
            esc_wait = 1'b0;
            if (c == tww_pkg::CH_ZERO || c == tww_pkg::CH_ONE) begin
                font_sel = (c == tww_pkg::CH_ONE);
                h = font_height_of(font_sel);
                if (pen == '0 || h > line_h)
                    line_h = h;
            end
        end else if (c == tww_pkg::CH_ESCAPE) begin
            emit_word(n);
            esc_wait = 1'b1;
        end else if (c == tww_pkg::CH_NEWLINE) begin
            emit_word(n);
            drop_line();
            pen = '0;
        end else begin
            if (c == tww_pkg::CH_SPACE) begin
                emit_word(n);
            end else begin
                if (!word_live) begin
                    word_live = 1'b1;
                    word_x0   = pen;
                    word_w    = '0;
                    word_len  = 0;
                    word_cut  = 1'b0;
                end
                if (word_len < WORD_CAP) begin
                    word_code[word_len] = c;
                    word_adv[word_len]  = adv;
                    word_len++;
                end else begin
                    word_cut = 1'b1;
                end
                word_w = add_clamp(word_w, adv);
            end
            pen = add_clamp(pen, adv);
            // past the wrap width: the open word restarts on a fresh line
            if (pen > cfg_wrap) begin
                word_x0 = '0;
                pen = word_live ? word_w : '0;
                drop_line();
            end
        end
        if (eot) begin
            emit_word(n);
            esc_wait = 1'b0;
        end
        if (n > 0) begin
            g = glyph_expect_q.pop_back();
            g.last = 1'b1;
            glyph_expect_q.push_back(g);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_char_req r;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || char_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (char_req_q.size() != 0) begin
                r = char_req_q.pop_front();
                s_axis_tdata  <= {7'd0, r.adv, r.code};
                s_axis_tlast  <= r.eot;
                s_axis_tvalid <= 1'b1;
                send_gap = r.gap;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // glyph sink back-pressure
    always @(negedge i_clk) begin
        if (glyph_taken)
            recv_stall = calm ? 0 : $urandom_range(0, 5);
        if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, check each accepted glyph
    always @(posedge i_clk) begin
        t_glyph g;
        char_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        glyph_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (char_taken)
            place_char(s_axis_tdata[CODE_W-1:0], s_axis_tdata[CODE_W +: ADV_W], s_axis_tlast);
        if (glyph_taken) begin
            if (glyph_expect_q.size() == 0) begin
                $error("glyph with none expected: code %0d", m_axis_tdata[CODE_W-1:0]);
                fail_count++;
            end else begin
                g = glyph_expect_q.pop_front();
                check_field("glyph_code", g.code, m_axis_tdata[CODE_W-1:0]);
                check_field("font_index", g.font, m_axis_tuser[0]);
                check_field("pen_x", g.x, m_axis_tdata[CODE_W +: X_W]);
                check_field("pen_y", longint'($signed(g.y)),
                            longint'($signed(m_axis_tdata[CODE_W + X_W +: Y_W])));
                check_field("last_in_run", g.last, m_axis_tlast);
                check_field("word_truncated", g.trunc, m_axis_tuser[1]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_char(input logic [CODE_W-1:0] code, input logic [ADV_W-1:0] adv,
                            input logic eot);
        t_char_req r;
        r.code = code;
        r.adv  = adv;
        r.eot  = eot;
        r.gap  = calm ? 0 : $urandom_range(0, 5);
        char_req_q.push_back(r);
        queued_count++;
    endtask

    function automatic logic [ADV_W-1:0] rand_adv(input int adv_max);
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return ADV_W'($urandom_range(0, 4095));
        return ADV_W'($urandom_range(0, adv_max));
    endfunction

    // mostly lower-case letters, sometimes any code point
    function automatic logic [CODE_W-1:0] word_letter();
        if ($urandom_range(0, 3) != 0)
            return CODE_W'($urandom_range(97, 122));
        return CODE_W'($urandom_range(0, 1114111));
    endfunction

    // random text: mostly words and separators, some escapes, some noise
    task automatic gen_text(input int count, input int adv_max);
        int start, pick, len;
        logic eot;
        start = queued_count;
        while (queued_count - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 8);
                eot = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++)
                    add_char(word_letter(), rand_adv(adv_max), eot && (k == len - 1));
                if (!eot) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14)
                        add_char(tww_pkg::CH_SPACE, rand_adv(adv_max), 1'b0);
                    else if (pick < 17)
                        add_char(tww_pkg::CH_NEWLINE, rand_adv(adv_max), 1'b0);
                end
            end else if (pick < 62) begin
                add_char(tww_pkg::CH_ESCAPE, rand_adv(adv_max), 1'b0);
                case ($urandom_range(0, 3))
                    0: add_char(tww_pkg::CH_ZERO, rand_adv(adv_max),
                                $urandom_range(0, 9) == 0);
                    1: add_char(tww_pkg::CH_ONE, rand_adv(adv_max),
                                $urandom_range(0, 9) == 0);
                    2: add_char(tww_pkg::CH_ZERO + CODE_W'($urandom_range(2, 9)),
                                rand_adv(adv_max), 1'b0);
                    default: add_char(CODE_W'($urandom_range(0, 1114111)),
                                      rand_adv(adv_max), 1'b0);
                endcase
            end else if (pick < 70) begin
                add_char(tww_pkg::CH_NEWLINE, rand_adv(adv_max), $urandom_range(0, 9) == 0);
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 3))
                    add_char(tww_pkg::CH_SPACE, rand_adv(adv_max), 1'b0);
            end else if (pick < 85) begin
                // escape as the final character of the text
                add_char(tww_pkg::CH_ESCAPE, rand_adv(adv_max), 1'b1);
            end else begin
                add_char(CODE_W'($urandom_range(0, 1114111)), ADV_W'($urandom_range(0, 4095)),
                         $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tww_pkg::CFG_WRAP_WIDTH: cfg_wrap = val;
            tww_pkg::CFG_LINE_H0:    cfg_lh0 = val[H_W-1:0];
            tww_pkg::CFG_LINE_H1:    cfg_lh1 = val[H_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [X_W-1:0] wrap, input logic [H_W-1:0] h0,
                              input logic [H_W-1:0] h1);
        write_reg(tww_pkg::CFG_WRAP_WIDTH, wrap);
        write_reg(tww_pkg::CFG_LINE_H0, CFG_D_W'(h0));
        write_reg(tww_pkg::CFG_LINE_H1, CFG_D_W'(h1));
    endtask

    // hold off until every request is taken and every glyph has arrived
    task automatic wait_idle();
        while (char_req_q.size() != 0 || s_axis_tvalid || glyph_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        int w;
        cfg_wrap  = tww_pkg::WRAP_WIDTH_RST;
        cfg_lh0   = tww_pkg::LINE_H0_RST;
        cfg_lh1   = tww_pkg::LINE_H1_RST;
        pen       = '0;
        base_y    = '0;
        line_h    = tww_pkg::LINE_H0_RST;
        font_sel  = 1'b0;
        esc_wait  = 1'b0;
        word_live = 1'b0;
        word_x0   = '0;
        word_w    = '0;
        word_len  = 0;
        word_cut  = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: font escapes, ignored digit, escaped newline, field extremes,
        // wrap inside a word, lone space at end of text, trailing escape
        add_char(tww_pkg::CH_ESCAPE, 12'd0, 1'b0);
        add_char(tww_pkg::CH_ONE, 12'd0, 1'b0);
        add_char(21'd65, 12'hFFF, 1'b0);
        add_char(21'd98, 12'd0, 1'b0);
        add_char(tww_pkg::CH_SPACE, 12'd160, 1'b0);
        add_char(tww_pkg::CH_ESCAPE, 12'd5, 1'b0);
        add_char(tww_pkg::CH_ZERO, 12'd7, 1'b0);
        add_char(tww_pkg::CH_ESCAPE, 12'd0, 1'b0);
        add_char(tww_pkg::CH_ZERO + 21'd5, 12'd100, 1'b0);
        add_char(tww_pkg::CH_ESCAPE, 12'd0, 1'b0);
        add_char(tww_pkg::CH_NEWLINE, 12'd0, 1'b0);
        add_char(21'h10FFFF, 12'hFFF, 1'b0);
        add_char(21'd0, 12'hFFF, 1'b0);
        add_char(tww_pkg::CH_NEWLINE, 12'd3, 1'b0);
        add_char(21'd119, 12'hFFF, 1'b0);
        add_char(21'd120, 12'hFFF, 1'b0);
        add_char(21'd121, 12'hFFF, 1'b1);
        add_char(tww_pkg::CH_SPACE, 12'd16, 1'b1);
        add_char(21'd113, 12'd16, 1'b0);
        add_char(tww_pkg::CH_ESCAPE, 12'd0, 1'b1);
        add_char(tww_pkg::CH_ONE, 12'd16, 1'b1);
        wait_idle();

        // zero wrap width: nearly every character wraps
        set_config(16'd0, 8'd1, 8'd255);
        gen_text(50, 64);
        wait_idle();

        // widest wrap and large advances: pen saturates
        calm = 1'b1;
        set_config(16'hFFFF, 8'd255, 8'd1);
        gen_text(50, 4095);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            w = (p % 2 == 0) ? $urandom_range(256, 4096) : $urandom_range(0, 65535);
            calm = (p == 2);
            set_config(X_W'(w), H_W'($urandom_range(1, 255)), H_W'($urandom_range(1, 255)));
            gen_text(50, (w / 5 > 4095) ? 4095 : (w / 5 < 1) ? 1 : w / 5);
            wait_idle();
        end

        // tallest lines in both fonts
        calm = 1'b0;
        set_config(16'd8192, 8'd255, 8'd255);
        gen_text(30, 600);
        wait_idle();

        if (fail_count == 0 && glyph_expect_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
sv/tww_pkg.sv
sv/tww_word_mem.sv
sv/tww_emitter.sv
sv/text_word_wrap_layout.sv
verif/tb.sv
